/* rtl/assert_macros.svh */
// Assertion helpers used by the RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define QRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define QRS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/qrs_pkg.sv */
package qrs_pkg;

  // Field widths.
  localparam int COEF_W    = 16;
  localparam int OUT_W     = 32;
  localparam int DISC_W    = 40;
  // Magnitude of the discriminant always stays below 2^34.
  localparam int MAG_W     = 34;
  localparam int MAG_PAIRS = MAG_W / 2;

  localparam int ROOT_FRAC_BITS_DEF = 16;

  // Status codes.
  localparam logic [1:0] ST_REAL  = 2'd0;
  localparam logic [1:0] ST_CPLX  = 2'd1;
  localparam logic [1:0] ST_AZERO = 2'd2;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
  } qrs_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [OUT_W-1:0]  first_value;
    logic signed [OUT_W-1:0]  second_value;
    logic signed [DISC_W-1:0] discriminant;
  } qrs_out_t;

  // Per-word information that travels alongside the arithmetic.
  typedef struct packed {
    logic                     a_zero;
    logic                     cplx;
    logic                     neg1;
    logic                     neg2;
    logic signed [DISC_W-1:0] disc;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
  } qrs_side_t;

endpackage

/* rtl/quadratic_root_solver.sv */
// Channel  Direction  Word       Handshake
// in_      input      qrs_in_t   in_valid, in_stall
// out_     output     qrs_out_t  out_valid, out_stall
//
// One word enters per cycle while in_stall is low; the pipeline depth is
// set by one square root cell per root bit and one divider cell per quotient
// bit, between the input, discriminant, numerator and output registers.
// Reset clears every valid bit of the pipeline and the output valid bit.
// A stalled output word freezes the whole pipeline, and in_stall follows
// out_stall in the same cycle while a result is waiting.
`include "assert_macros.svh"

module quadratic_root_solver #(
  parameter int ROOT_FRAC_BITS = qrs_pkg::ROOT_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  qrs_pkg::qrs_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output qrs_pkg::qrs_out_t out_word
);

  localparam int COEF_W = qrs_pkg::COEF_W;
  localparam int OUT_W  = qrs_pkg::OUT_W;
  localparam int DISC_W = qrs_pkg::DISC_W;
  localparam int MAG_W  = qrs_pkg::MAG_W;
  localparam int SQ_N   = qrs_pkg::MAG_PAIRS + ROOT_FRAC_BITS;
  localparam int ROOT_W = SQ_N;
  localparam int REM_W  = SQ_N + 2;
  localparam int NB_W   = COEF_W + 1 + ROOT_FRAC_BITS;
  localparam int NUM_W  = SQ_N + 1;
  localparam int DEN_W  = COEF_W + 1;
  localparam int QX_W   = (NUM_W > OUT_W) ? NUM_W : OUT_W;
  localparam int PROD_W = 2 * COEF_W;

  localparam logic [QX_W-1:0] POS_LIM =
    {{(QX_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic [QX_W-1:0] NEG_LIM = POS_LIM + QX_W'(1);
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic en;

  // The pipeline moves unless a finished word is held by the receiver.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 0: the two products.
  logic                     v0_r;
  logic signed [COEF_W-1:0] a0_r, b0_r;
  logic signed [PROD_W-1:0] bb0_r, ac0_r, bb_nxt, ac_nxt;

  assign bb_nxt = in_word.coef_b * in_word.coef_b;
  assign ac_nxt = in_word.coef_a * in_word.coef_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r  <= in_word.coef_a;
      b0_r  <= in_word.coef_b;
      bb0_r <= bb_nxt;
      ac0_r <= ac_nxt;
    end
  end

  // Stage 1: discriminant and its magnitude.
  logic                     v1_r;
  qrs_pkg::qrs_side_t       side1_r, side1_nxt;
  logic [MAG_W-1:0]         mag1_r;
  logic signed [DISC_W-1:0] d_nxt, dabs;

  always_comb begin
    d_nxt            = DISC_W'(bb0_r) - (DISC_W'(ac0_r) <<< 2);
    dabs             = d_nxt[DISC_W-1] ? -d_nxt : d_nxt;
    side1_nxt.a_zero = (a0_r == '0);
    side1_nxt.cplx   = d_nxt[DISC_W-1];
    side1_nxt.neg1   = 1'b0;
    side1_nxt.neg2   = 1'b0;
    side1_nxt.disc   = d_nxt;
    side1_nxt.coef_a = a0_r;
    side1_nxt.coef_b = b0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side1_nxt;
      mag1_r  <= dabs[MAG_W-1:0];
    end
  end

  // Square root chain, one root bit per cell.
  logic               sq_valid [0:SQ_N];
  qrs_pkg::qrs_side_t sq_side  [0:SQ_N];
  logic [MAG_W-1:0]   sq_mag   [0:SQ_N];
  logic [ROOT_W-1:0]  sq_root  [0:SQ_N];
  logic [REM_W-1:0]   sq_rem   [0:SQ_N];

  assign sq_valid[0] = v1_r;
  assign sq_side[0]  = side1_r;
  assign sq_mag[0]   = mag1_r;
  assign sq_root[0]  = '0;
  assign sq_rem[0]   = '0;

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    qrs_sqrt_cell #(
      .ROOT_W (ROOT_W),
      .REM_W  (REM_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (sq_valid[i]),
      .side_i  (sq_side[i]),
      .mag_i   (sq_mag[i]),
      .root_i  (sq_root[i]),
      .rem_i   (sq_rem[i]),
      .valid_o (sq_valid[i+1]),
      .side_o  (sq_side[i+1]),
      .mag_o   (sq_mag[i+1]),
      .root_o  (sq_root[i+1]),
      .rem_o   (sq_rem[i+1])
    );
  end

  // Numerator stage: form both numerators, split into sign and magnitude.
  logic                     vn_r;
  qrs_pkg::qrs_side_t       siden_r, siden_nxt;
  logic [NUM_W-1:0]         num1_r, num2_r;
  logic [DEN_W-1:0]         den_r;
  logic signed [NB_W-1:0]   b_wide, nb;
  logic signed [NUM_W:0]    nbx, rx, n1s, n2s, n1a, n2a;
  logic [COEF_W-1:0]        abs_a;

  always_comb begin
    siden_nxt      = sq_side[SQ_N];
    b_wide         = NB_W'(siden_nxt.coef_b);
    nb             = -(b_wide <<< ROOT_FRAC_BITS);
    nbx            = (NUM_W+1)'(nb);
    rx             = $signed({2'b00, sq_root[SQ_N]});
    n1s            = siden_nxt.cplx ? nbx : nbx + rx;
    n2s            = siden_nxt.cplx ? rx  : nbx - rx;
    n1a            = n1s[NUM_W] ? -n1s : n1s;
    n2a            = n2s[NUM_W] ? -n2s : n2s;
    abs_a          = siden_nxt.coef_a[COEF_W-1] ? COEF_W'(-siden_nxt.coef_a)
                                                : COEF_W'(siden_nxt.coef_a);
    siden_nxt.neg1 = n1s[NUM_W] ^ siden_nxt.coef_a[COEF_W-1];
    siden_nxt.neg2 = n2s[NUM_W] ^ siden_nxt.coef_a[COEF_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn_r <= 1'b0;
    end else if (en) begin
      vn_r <= sq_valid[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      siden_r <= siden_nxt;
      num1_r  <= n1a[NUM_W-1:0];
      num2_r  <= n2a[NUM_W-1:0];
      den_r   <= {abs_a, 1'b0};
    end
  end

  // Divider chain, one quotient bit per cell for both roots.
  logic               dv_valid [0:NUM_W];
  qrs_pkg::qrs_side_t dv_side  [0:NUM_W];
  logic [DEN_W-1:0]   dv_den   [0:NUM_W];
  logic [NUM_W-1:0]   dv_num1  [0:NUM_W];
  logic [NUM_W-1:0]   dv_num2  [0:NUM_W];
  logic [DEN_W-1:0]   dv_rem1  [0:NUM_W];
  logic [DEN_W-1:0]   dv_rem2  [0:NUM_W];

  assign dv_valid[0] = vn_r;
  assign dv_side[0]  = siden_r;
  assign dv_den[0]   = den_r;
  assign dv_num1[0]  = num1_r;
  assign dv_num2[0]  = num2_r;
  assign dv_rem1[0]  = '0;
  assign dv_rem2[0]  = '0;

  for (genvar j = 0; j < NUM_W; j++) begin : g_div
    qrs_div_cell #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (dv_valid[j]),
      .side_i  (dv_side[j]),
      .den_i   (dv_den[j]),
      .num1_i  (dv_num1[j]),
      .num2_i  (dv_num2[j]),
      .rem1_i  (dv_rem1[j]),
      .rem2_i  (dv_rem2[j]),
      .valid_o (dv_valid[j+1]),
      .side_o  (dv_side[j+1]),
      .den_o   (dv_den[j+1]),
      .num1_o  (dv_num1[j+1]),
      .num2_o  (dv_num2[j+1]),
      .rem1_o  (dv_rem1[j+1]),
      .rem2_o  (dv_rem2[j+1])
    );
  end

  // Apply the sign, saturate, and register the result word.
  function automatic logic signed [OUT_W-1:0] sat_q(input logic [QX_W-1:0] q,
                                                    input logic neg);
    logic signed [OUT_W-1:0] res;
    if (neg) begin
      res = (q > NEG_LIM) ? OUT_MIN : -$signed(q[OUT_W-1:0]);
    end else begin
      res = (q > POS_LIM) ? OUT_MAX : $signed(q[OUT_W-1:0]);
    end
    return res;
  endfunction

  logic               out_valid_r;
  qrs_pkg::qrs_out_t  out_word_r, out_nxt;
  qrs_pkg::qrs_side_t sidef;

  always_comb begin
    sidef                = dv_side[NUM_W];
    out_nxt.discriminant = sidef.disc;
    if (sidef.a_zero) begin
      out_nxt.status       = qrs_pkg::ST_AZERO;
      out_nxt.first_value  = '0;
      out_nxt.second_value = '0;
    end else begin
      out_nxt.status       = sidef.cplx ? qrs_pkg::ST_CPLX : qrs_pkg::ST_REAL;
      out_nxt.first_value  = sat_q(QX_W'(dv_num1[NUM_W]), sidef.neg1);
      out_nxt.second_value = sat_q(QX_W'(dv_num2[NUM_W]), sidef.neg2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Checks on the result word and the last pipeline step.
  `QRS_ASSERT_NOW(a_azero_zero, out_valid && out_word.status == qrs_pkg::ST_AZERO, out_word.first_value == '0 && out_word.second_value == '0, "zero leading coefficient gave nonzero roots")
  `QRS_ASSERT_NOW(a_real_disc, out_valid && out_word.status == qrs_pkg::ST_REAL, !out_word.discriminant[DISC_W-1], "real roots with negative discriminant")
  `QRS_ASSERT_NOW(a_cplx_disc, out_valid && out_word.status == qrs_pkg::ST_CPLX, out_word.discriminant[DISC_W-1], "complex pair with non-negative discriminant")
  `QRS_ASSERT_NXT(a_last_to_out, en && dv_valid[NUM_W], out_valid, "finished word did not reach the output")

endmodule

/* rtl/qrs_sqrt_cell.sv */
module qrs_sqrt_cell #(
  parameter int ROOT_W = 33,
  parameter int REM_W  = 35
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      valid_i,
  input  qrs_pkg::qrs_side_t        side_i,
  input  logic [qrs_pkg::MAG_W-1:0] mag_i,
  input  logic [ROOT_W-1:0]         root_i,
  input  logic [REM_W-1:0]          rem_i,
  output logic                      valid_o,
  output qrs_pkg::qrs_side_t        side_o,
  output logic [qrs_pkg::MAG_W-1:0] mag_o,
  output logic [ROOT_W-1:0]         root_o,
  output logic [REM_W-1:0]          rem_o
);

  logic                      valid_r;
  qrs_pkg::qrs_side_t        side_r;
  logic [qrs_pkg::MAG_W-1:0] mag_r, mag_nxt;
  logic [ROOT_W-1:0]         root_r, root_nxt;
  logic [REM_W-1:0]          rem_r, rem_nxt;
  logic [REM_W+1:0]          rem_sh, trial, diff;
  logic                      fit;

  // One digit-by-digit square root step: bring down a pair, try 4*root+1.
  always_comb begin
    rem_sh   = {rem_i, mag_i[qrs_pkg::MAG_W-1 -: 2]};
    trial    = {{(REM_W-ROOT_W){1'b0}}, root_i, 2'b01};
    diff     = rem_sh - trial;
    fit      = (rem_sh >= trial);
    rem_nxt  = fit ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    root_nxt = {root_i[ROOT_W-2:0], fit};
    mag_nxt  = {mag_i[qrs_pkg::MAG_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      mag_r  <= mag_nxt;
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign mag_o   = mag_r;
  assign root_o  = root_r;
  assign rem_o   = rem_r;

endmodule

/* rtl/qrs_div_cell.sv */
module qrs_div_cell #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 17
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_i,
  input  qrs_pkg::qrs_side_t side_i,
  input  logic [DEN_W-1:0]   den_i,
  input  logic [NUM_W-1:0]   num1_i,
  input  logic [NUM_W-1:0]   num2_i,
  input  logic [DEN_W-1:0]   rem1_i,
  input  logic [DEN_W-1:0]   rem2_i,
  output logic               valid_o,
  output qrs_pkg::qrs_side_t side_o,
  output logic [DEN_W-1:0]   den_o,
  output logic [NUM_W-1:0]   num1_o,
  output logic [NUM_W-1:0]   num2_o,
  output logic [DEN_W-1:0]   rem1_o,
  output logic [DEN_W-1:0]   rem2_o
);

  logic               valid_r;
  qrs_pkg::qrs_side_t side_r;
  logic [DEN_W-1:0]   den_r;
  logic [NUM_W-1:0]   num1_r, num2_r, num1_nxt, num2_nxt;
  logic [DEN_W-1:0]   rem1_r, rem2_r, rem1_nxt, rem2_nxt;
  logic [DEN_W:0]     rsh1, rsh2, dif1, dif2, den_x;
  logic               fit1, fit2;

  // One restoring division step for each of the two numerators.
  // The numerator shifts out at the top while quotient bits enter below.
  always_comb begin
    den_x    = {1'b0, den_i};
    rsh1     = {rem1_i, num1_i[NUM_W-1]};
    rsh2     = {rem2_i, num2_i[NUM_W-1]};
    dif1     = rsh1 - den_x;
    dif2     = rsh2 - den_x;
    fit1     = (rsh1 >= den_x);
    fit2     = (rsh2 >= den_x);
    rem1_nxt = fit1 ? dif1[DEN_W-1:0] : rsh1[DEN_W-1:0];
    rem2_nxt = fit2 ? dif2[DEN_W-1:0] : rsh2[DEN_W-1:0];
    num1_nxt = {num1_i[NUM_W-2:0], fit1};
    num2_nxt = {num2_i[NUM_W-2:0], fit2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      den_r  <= den_i;
      num1_r <= num1_nxt;
      num2_r <= num2_nxt;
      rem1_r <= rem1_nxt;
      rem2_r <= rem2_nxt;
    end
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign den_o   = den_r;
  assign num1_o  = num1_r;
  assign num2_o  = num2_r;
  assign rem1_o  = rem1_r;
  assign rem2_o  = rem2_r;

endmodule

/* bench/quadratic_root_checker.sv */
`timescale 1ns / 100ps

module quadratic_root_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  qrs_pkg::qrs_in_t  in_word,
  input  logic              out_valid,
  input  logic              out_stall,
  input  qrs_pkg::qrs_out_t out_word,
  output int                fail_count,
  output int                pending_roots,
  output int                solved_count
);

  localparam int ROOT_FRAC = qrs_pkg::ROOT_FRAC_BITS_DEF;

  qrs_pkg::qrs_out_t root_queue[$];

  // Bit-serial integer square root of mag scaled by 4^ROOT_FRAC.
  function automatic longint unsigned scaled_sqrt(longint unsigned mag);
    longint unsigned root;
    longint unsigned rem;
    longint unsigned pair;
    longint unsigned trial;
    root = 0;
    rem = 0;
    for (int i = qrs_pkg::MAG_PAIRS + ROOT_FRAC - 1; i >= 0; i--) begin
      pair = 0;
      if (2 * i >= 2 * ROOT_FRAC) begin
        pair = (mag >> (2 * i - 2 * ROOT_FRAC)) & 64'd3;
      end
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic signed [qrs_pkg::OUT_W-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[qrs_pkg::OUT_W-1:0];
  endfunction

  // Roots of one coefficient set; SV division truncates toward zero.
  function automatic qrs_pkg::qrs_out_t solve_roots(qrs_pkg::qrs_in_t w);
    qrs_pkg::qrs_out_t res;
    longint a;
    longint b;
    longint c;
    longint d;
    longint r;
    longint nb;
    longint den;
    a = w.coef_a;
    b = w.coef_b;
    c = w.coef_c;
    d = b * b - 4 * a * c;
    res = '0;
    res.discriminant = d[qrs_pkg::DISC_W-1:0];
    if (a == 0) begin
      res.status = qrs_pkg::ST_AZERO;
    end else begin
      r = longint'(scaled_sqrt(d < 0 ? -d : d));
      nb = -b * (longint'(1) << ROOT_FRAC);
      den = 2 * a;
      if (d < 0) begin
        res.status = qrs_pkg::ST_CPLX;
        res.first_value = clamp32(nb / den);
        res.second_value = clamp32(r / den);
      end else begin
        res.status = qrs_pkg::ST_REAL;
        res.first_value = clamp32((nb + r) / den);
        res.second_value = clamp32((nb - r) / den);
      end
    end
    return res;
  endfunction

  assign pending_roots = root_queue.size();

  // Predict on each accepted input word, compare each accepted output word.
  always @(posedge clk) begin
    qrs_pkg::qrs_out_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      solved_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        root_queue.push_back(solve_roots(in_word));
      end
      if (out_valid && !out_stall) begin
        solved_count <= solved_count + 1;
        if (root_queue.size() == 0) begin
          $error("unexpected result word %h", out_word);
          errs++;
        end else begin
          want = root_queue.pop_front();
          if (want.status !== out_word.status) begin
            $error("status: expected %0d, got %0d", want.status, out_word.status);
            errs++;
          end
          if (want.first_value !== out_word.first_value) begin
            $error("first_value: expected %0d, got %0d",
                   want.first_value, out_word.first_value);
            errs++;
          end
          if (want.second_value !== out_word.second_value) begin
            $error("second_value: expected %0d, got %0d",
                   want.second_value, out_word.second_value);
            errs++;
          end
          if (want.discriminant !== out_word.discriminant) begin
            $error("discriminant: expected %0d, got %0d",
                   want.discriminant, out_word.discriminant);
            errs++;
          end
        end
      end
      if (errs != 0) begin
        fail_count <= fail_count + errs;
      end
    end
  end
endmodule

/* bench/quadratic_root_solver_test.sv */
`timescale 1ns / 100ps

module quadratic_root_solver_test;

  localparam int LATENCY = 71;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_WORDS = 1800;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  qrs_pkg::qrs_in_t  in_word = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  qrs_pkg::qrs_out_t out_word;
  int                fail_count;
  int                pending_roots;
  int                solved_count;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;
  int sent_count = 0;

  always #5 clk = ~clk;

  quadratic_root_solver u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  quadratic_root_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .fail_count(fail_count), .pending_roots(pending_roots),
    .solved_count(solved_count)
  );

  // Receiver stall: random, or a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles with no accepted word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one word, idling first at random, and wait until it is taken.
  task automatic send_word(input qrs_pkg::qrs_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sent_count++;
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    drop_valid();
    while (pending_roots != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic qrs_pkg::qrs_in_t make_word(int a, int b, int c);
    qrs_pkg::qrs_in_t w;
    w.coef_a = a[15:0];
    w.coef_b = b[15:0];
    w.coef_c = c[15:0];
    return w;
  endfunction

  // Half small-magnitude coefficients so roots stay in range; the rest full range or extremes.
  function automatic logic [15:0] pick_coef();
    case ($urandom_range(3))
      0: return 16'($urandom());
      1: return 16'($signed($urandom_range(2048)) - 1024);
      2: return 16'($signed($urandom_range(512)) - 256);
      default: return $urandom_range(1) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  function automatic qrs_pkg::qrs_in_t random_word();
    qrs_pkg::qrs_in_t w;
    w.coef_a = pick_coef();
    w.coef_b = pick_coef();
    w.coef_c = pick_coef();
    if ($urandom_range(19) == 0) begin
      w.coef_a = '0;
    end
    return w;
  endfunction

  initial begin
    int lim[6];
    lim = '{-32768, 32767, 0, 1, -1, 256};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, zero leading coefficient, real, double and complex roots.
    send_word(make_word(256, -768, 512));
    send_word(make_word(256, 512, 256));
    send_word(make_word(256, 0, 256));
    send_word(make_word(-256, 0, -256));
    send_word(make_word(0, 300, 5));
    send_word(make_word(0, -32768, 0));
    send_word(make_word(1, -32768, -32768));
    send_word(make_word(-32768, -32768, 32767));
    send_word(make_word(32767, 32767, 32767));
    send_word(make_word(-32768, 32767, -32768));
    send_word(make_word(1, 32767, 0));
    send_word(make_word(-1, 0, 32767));
    for (int i = 0; i < 12; i++) begin
      send_word(make_word(lim[i % 6], lim[(i + 2) % 6], lim[(i * 5 + 1) % 6]));
    end
    wait_drained();

    // Random phases with different idling mixes.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (int n = 0; n < RANDOM_WORDS / 4; n++) begin
        send_word(random_word());
      end
      // The sender pauses until every expected result is back.
      wait_drained();
    end

    // Receiver holds off long enough for the pipeline to fill and back up.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (3 * LATENCY) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        for (int n = 0; n < 2 * LATENCY; n++) begin
          send_word(random_word());
        end
      end
    join
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);

    $display("Solved %0d coefficient sets (%0d results checked) across idle, stall",
             sent_count, solved_count);
    $display("and back-pressure phases, with directed extremes and zero leading terms.");
    if (fail_count == 0 && pending_roots == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
